// ----- hdl/border_flood_hole_fill_macros.svh -----
// Assertion helpers used by border_flood_hole_fill.sv.
`ifndef BORDER_FLOOD_HOLE_FILL_MACROS_SVH
`define BORDER_FLOOD_HOLE_FILL_MACROS_SVH

`ifndef SYNTHESIS
`define BFHF_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define BFHF_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define BFHF_ASSERT(lbl, clk, rstn, prop)
`define BFHF_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- hdl/bfhf_pkg.sv -----
package bfhf_pkg;

	localparam int MAX_SIDE = 32;
	localparam int IDX_W    = $clog2(MAX_SIDE);
	localparam int ADDR_W   = 2 * IDX_W;
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int QPTR_W   = ADDR_W + 1;
	localparam int SIDE_W   = 6;
	localparam int CELL_W   = 2;
	localparam int OP_W     = 2;

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [OP_W-1:0]   op_t;

	localparam op_t OP_WRITE = 2'd0;
	localparam op_t OP_FILL  = 2'd1;
	localparam op_t OP_READ  = 2'd2;

	localparam cell_t CELL_OPEN = 2'd0;
	localparam cell_t CELL_WALL = 2'd1;
	localparam cell_t CELL_HOLE = 2'd2;

	localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(32);
	localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

endpackage

// ----- hdl/border_flood_hole_fill.sv -----
// Write and unused opcodes complete in the idle state. A read goes through a wait state
// and then raises result_valid, later while an earlier result is still held by result_stall.
// A fill first runs the marking scan over every cell of the active square (a read state and
// a write state per cell), then floods from the queue: per queued cell a queue read plus up
// to four neighbor probes, each a grid read and a check.
// Items are taken one at a time. Reset clears control state and sets side_length to 32;
// the grid is undefined until written and gets no clearing pass.
module border_flood_hole_fill (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bfhf_pkg::SIDE_W-1:0]  cfg_data,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [bfhf_pkg::OP_W-1:0]    op,
	input  logic [bfhf_pkg::IDX_W-1:0]   row,
	input  logic [bfhf_pkg::IDX_W-1:0]   column,
	input  logic                         pixel,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [bfhf_pkg::CELL_W-1:0]  cell_value
);

	import bfhf_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_RD_WAIT = 4'd1;
	localparam logic [3:0] ST_SCAN_RD = 4'd2;
	localparam logic [3:0] ST_SCAN_WR = 4'd3;
	localparam logic [3:0] ST_Q_RD    = 4'd4;
	localparam logic [3:0] ST_Q_WAIT  = 4'd5;
	localparam logic [3:0] ST_NB_SEL  = 4'd6;
	localparam logic [3:0] ST_NB_CHK  = 4'd7;

	logic [3:0]        state_q;
	logic [SIDE_W-1:0] side_q;
	logic [IDX_W-1:0]  s_m1_q;
	logic [IDX_W-1:0]  r_q;
	logic [IDX_W-1:0]  c_q;
	logic [1:0]        k_q;
	addr_t             addr_q;
	addr_t             nb_addr_q;
	qptr_t             head_q;
	qptr_t             tail_q;
	logic              result_valid_q;
	cell_t             cell_value_q;

	logic              accept;
	logic [SIDE_W-1:0] side_clamp;
	logic [IDX_W-1:0]  s_m1;
	logic              scan_border;
	logic              nb_ok;
	logic [IDX_W-1:0]  nb_r;
	logic [IDX_W-1:0]  nb_c;

	logic  g_we;
	addr_t g_waddr;
	cell_t g_wdata;
	addr_t g_raddr;
	cell_t g_rdata;
	logic  q_we;
	addr_t q_wdata;
	addr_t q_rdata;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign cell_value   = cell_value_q;

	always_comb begin
		side_clamp = side_q;
		if (side_q == '0) begin
			side_clamp = SIDE_W'(1);
		end else if (side_q > SIDE_MAX) begin
			side_clamp = SIDE_MAX;
		end
	end

	assign s_m1 = IDX_W'(side_clamp - SIDE_W'(1));

	assign scan_border = (r_q == '0) || (c_q == '0) || (r_q == s_m1_q) || (c_q == s_m1_q);

	// Neighbor order: down, right, up, left.
	always_comb begin
		nb_r  = r_q;
		nb_c  = c_q;
		nb_ok = 1'b0;
		case (k_q)
			2'd0: begin
				nb_ok = (r_q != s_m1_q);
				nb_r  = IDX_W'(r_q + 1'b1);
			end
			2'd1: begin
				nb_ok = (c_q != s_m1_q);
				nb_c  = IDX_W'(c_q + 1'b1);
			end
			2'd2: begin
				nb_ok = (r_q != '0);
				nb_r  = IDX_W'(r_q - 1'b1);
			end
			default: begin
				nb_ok = (c_q != '0);
				nb_c  = IDX_W'(c_q - 1'b1);
			end
		endcase
	end

	always_comb begin
		g_raddr = {row, column};
		unique case (state_q)
			ST_RD_WAIT: g_raddr = addr_q;
			ST_SCAN_RD: g_raddr = {r_q, c_q};
			ST_NB_SEL:  g_raddr = {nb_r, nb_c};
			default:    g_raddr = {row, column};
		endcase
	end

	always_comb begin
		g_we    = 1'b0;
		g_waddr = {row, column};
		g_wdata = {1'b0, pixel};
		q_we    = 1'b0;
		q_wdata = {r_q, c_q};
		unique case (state_q)
			ST_IDLE: begin
				g_we = accept && (op == OP_WRITE);
			end
			ST_SCAN_WR: begin
				if (g_rdata != CELL_WALL) begin
					g_we    = 1'b1;
					g_waddr = {r_q, c_q};
					g_wdata = scan_border ? CELL_OPEN : CELL_HOLE;
					q_we    = scan_border;
				end
			end
			ST_NB_CHK: begin
				if (g_rdata == CELL_HOLE) begin
					g_we    = 1'b1;
					g_waddr = nb_addr_q;
					g_wdata = CELL_OPEN;
					q_we    = 1'b1;
					q_wdata = nb_addr_q;
				end
			end
			default: begin
				g_we = 1'b0;
			end
		endcase
	end

	bfhf_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_grid (
		.clk  (clk),
		.we   (g_we),
		.waddr(g_waddr),
		.wdata(g_wdata),
		.raddr(g_raddr),
		.rdata(g_rdata)
	);

	bfhf_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(CELLS)
	) u_queue (
		.clk  (clk),
		.we   (q_we),
		.waddr(tail_q[ADDR_W-1:0]),
		.wdata(q_wdata),
		.raddr(head_q[ADDR_W-1:0]),
		.rdata(q_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			side_q         <= SIDE_RESET;
			s_m1_q         <= '0;
			r_q            <= '0;
			c_q            <= '0;
			k_q            <= '0;
			addr_q         <= '0;
			nb_addr_q      <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			result_valid_q <= 1'b0;
			cell_value_q   <= CELL_OPEN;
		end else begin
			if (cfg_valid && cfg_ready) begin
				side_q <= cfg_data;
			end
			if (result_valid_q && !result_stall && (state_q != ST_RD_WAIT)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_FILL: begin
								s_m1_q  <= s_m1;
								r_q     <= '0;
								c_q     <= '0;
								head_q  <= '0;
								tail_q  <= '0;
								state_q <= ST_SCAN_RD;
							end
							OP_READ: begin
								addr_q  <= {row, column};
								state_q <= ST_RD_WAIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD_WAIT: begin
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						cell_value_q   <= g_rdata;
						state_q        <= ST_IDLE;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_WR;
				end
				ST_SCAN_WR: begin
					if (q_we) begin
						tail_q <= QPTR_W'(tail_q + 1'b1);
					end
					if (c_q == s_m1_q) begin
						c_q <= '0;
						if (r_q == s_m1_q) begin
							state_q <= ST_Q_RD;
						end else begin
							r_q     <= IDX_W'(r_q + 1'b1);
							state_q <= ST_SCAN_RD;
						end
					end else begin
						c_q     <= IDX_W'(c_q + 1'b1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_Q_RD: begin
					if (head_q < tail_q) begin
						head_q  <= QPTR_W'(head_q + 1'b1);
						state_q <= ST_Q_WAIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_Q_WAIT: begin
					r_q     <= q_rdata[ADDR_W-1:IDX_W];
					c_q     <= q_rdata[IDX_W-1:0];
					k_q     <= '0;
					state_q <= ST_NB_SEL;
				end
				ST_NB_SEL: begin
					nb_addr_q <= {nb_r, nb_c};
					if (nb_ok) begin
						state_q <= ST_NB_CHK;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? ST_Q_RD : ST_NB_SEL;
					end
				end
				ST_NB_CHK: begin
					if (q_we) begin
						tail_q <= QPTR_W'(tail_q + 1'b1);
					end
					k_q     <= k_q + 1'b1;
					state_q <= (k_q == 2'd3) ? ST_Q_RD : ST_NB_SEL;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`include "border_flood_hole_fill_macros.svh"

	`BFHF_ASSERT(a_head_le_tail, clk, arst_n, head_q <= tail_q)
	`BFHF_ASSERT(a_tail_bounded, clk, arst_n, tail_q <= QPTR_W'(CELLS))
	`BFHF_ASSERT(a_result_from_read, clk, arst_n, $rose(result_valid_q) |-> $past(state_q) == ST_RD_WAIT)
	`BFHF_ASSERT_NEVER(a_enqueue_opens, clk, arst_n, q_we && !(g_we && g_wdata == CELL_OPEN))

endmodule

// ----- hdl/bfhf_ram.sv -----
module bfhf_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
